### rtl/core/umc_pkg.sv
// ----------------------------------------------------------------------------
// umc_pkg
// Shared widths, types, constants and helpers for the upwind momentum cell
// update pipeline.
// ----------------------------------------------------------------------------
package umc_pkg;

  localparam int FRAC_BITS = 32;
  localparam int DATA_W    = 48;
  localparam int REG_W     = 47;
  localparam int SUM_W     = DATA_W + 1;
  localparam int OP_W      = DATA_W + 3;
  localparam int HALF_W    = (OP_W + 1) / 2;
  localparam int HI_W      = OP_W - HALF_W;
  localparam int MID_W     = HALF_W + HI_W + 1;
  localparam int PROD_W    = 2 * OP_W;
  localparam int RND_W     = PROD_W + 1 - FRAC_BITS;
  localparam int MUL_LAT   = 5;
  localparam int LAT       = 3 * MUL_LAT + 4;
  localparam int H_DLY     = 3 * MUL_LAT + 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic        [REG_W-1:0]  reg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP      = 3'd0,
    REG_INV_DX         = 3'd1,
    REG_INV_DY         = 3'd2,
    REG_INV_DX_SQUARED = 3'd3,
    REG_INV_DY_SQUARED = 3'd4,
    REG_INV_REYNOLDS   = 3'd5
  } cfg_idx_t;

  localparam reg_t TIME_STEP_RST    = REG_W'(64'd4294967);
  localparam reg_t INV_D_RST        = REG_W'(64'd343597383680);
  localparam reg_t INV_D_SQ_RST     = REG_W'(64'd27487790694400);
  localparam reg_t INV_REYNOLDS_RST = REG_W'(64'd42949673);

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [PROD_W:0] RND_FULL = (PROD_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << FRAC_BITS;

  localparam logic [RND_W-1:0] LIM_POS = {{(RND_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic [RND_W-1:0] LIM_NEG = LIM_POS + 1'b1;

  typedef struct packed {
    logic  ydir;
    data_t h;
    data_t upa;
    data_t upb;
    data_t upp;
    data_t upm;
    sum_t  sa;
    sum_t  sb;
    sum_t  cp;
    sum_t  cm;
    op_t   lap_al;
    op_t   lap_ac;
    sum_t  pdiff;
  } front_t;

  function automatic sum_t sx_sum(input data_t v);
    return {v[DATA_W-1], v};
  endfunction

  function automatic op_t sx_op(input sum_t v);
    return {{(OP_W-SUM_W){v[SUM_W-1]}}, v};
  endfunction

  function automatic op_t zx_op(input reg_t v);
    return {{(OP_W-REG_W){1'b0}}, v};
  endfunction

endpackage

### rtl/core/umc_fmul.sv
// ----------------------------------------------------------------------------
// umc_fmul
// Pipelined signed fixed-point multiply: sign/magnitude split, four partial
// products, merge, round half away from zero (optionally halved), saturate to 48 bits.
// ----------------------------------------------------------------------------
module umc_fmul (
  input  logic           clk,
  input  umc_pkg::op_t   op_a,
  input  umc_pkg::op_t   op_b,
  input  logic           half,
  output umc_pkg::data_t product,
  output logic           sat
);

  function automatic logic [umc_pkg::OP_W-1:0] mag(input umc_pkg::op_t v);
    return v[umc_pkg::OP_W-1] ? -v : v;
  endfunction

  // stage 0: sign and magnitudes
  logic                      neg_s0_r, half_s0_r;
  logic [umc_pkg::OP_W-1:0]  mag_a_s0_r, mag_b_s0_r;

  // stage 1: partial products
  logic                                       neg_s1_r, half_s1_r;
  logic [2*umc_pkg::HALF_W-1:0]               pp_ll_r;
  logic [umc_pkg::HALF_W+umc_pkg::HI_W-1:0]   pp_lh_r, pp_hl_r;
  logic [2*umc_pkg::HI_W-1:0]                 pp_hh_r;

  // stage 2: full product
  logic                       neg_s2_r, half_s2_r;
  logic [umc_pkg::MID_W-1:0]  mid;
  logic [umc_pkg::PROD_W-1:0] prod_nxt, prod_s2_r;

  // stage 3: rounded magnitude
  logic                       neg_s3_r;
  logic [umc_pkg::PROD_W:0]   rsum;
  logic [umc_pkg::RND_W-1:0]  rnd_nxt, rnd_s3_r;

  // stage 4: saturate and sign
  logic                       over;
  umc_pkg::data_t             product_nxt, product_r;
  logic                       sat_r;

  always_ff @(posedge clk) begin
    neg_s0_r   <= op_a[umc_pkg::OP_W-1] ^ op_b[umc_pkg::OP_W-1];
    half_s0_r  <= half;
    mag_a_s0_r <= mag(op_a);
    mag_b_s0_r <= mag(op_b);
  end

  always_ff @(posedge clk) begin
    neg_s1_r  <= neg_s0_r;
    half_s1_r <= half_s0_r;
    pp_ll_r   <= mag_a_s0_r[umc_pkg::HALF_W-1:0] * mag_b_s0_r[umc_pkg::HALF_W-1:0];
    pp_lh_r   <= mag_a_s0_r[umc_pkg::HALF_W-1:0]
                 * mag_b_s0_r[umc_pkg::OP_W-1:umc_pkg::HALF_W];
    pp_hl_r   <= mag_a_s0_r[umc_pkg::OP_W-1:umc_pkg::HALF_W]
                 * mag_b_s0_r[umc_pkg::HALF_W-1:0];
    pp_hh_r   <= mag_a_s0_r[umc_pkg::OP_W-1:umc_pkg::HALF_W]
                 * mag_b_s0_r[umc_pkg::OP_W-1:umc_pkg::HALF_W];
  end

  always_comb begin
    mid      = {1'b0, pp_lh_r} + {1'b0, pp_hl_r};
    prod_nxt = {pp_hh_r, pp_ll_r}
               + {{(umc_pkg::PROD_W-umc_pkg::MID_W-umc_pkg::HALF_W){1'b0}},
                  mid, {umc_pkg::HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    neg_s2_r  <= neg_s1_r;
    half_s2_r <= half_s1_r;
    prod_s2_r <= prod_nxt;
  end

  always_comb begin
    rsum = {1'b0, prod_s2_r} + (half_s2_r ? umc_pkg::RND_HALF : umc_pkg::RND_FULL);
    if (half_s2_r) begin
      rnd_nxt = umc_pkg::RND_W'(rsum[umc_pkg::PROD_W:umc_pkg::FRAC_BITS+1]);
    end else begin
      rnd_nxt = rsum[umc_pkg::PROD_W:umc_pkg::FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    neg_s3_r <= neg_s2_r;
    rnd_s3_r <= rnd_nxt;
  end

  always_comb begin
    over = neg_s3_r ? (rnd_s3_r > umc_pkg::LIM_NEG) : (rnd_s3_r > umc_pkg::LIM_POS);
    if (over) begin
      product_nxt = neg_s3_r ? umc_pkg::DATA_MIN : umc_pkg::DATA_MAX;
    end else if (neg_s3_r) begin
      product_nxt = -rnd_s3_r[umc_pkg::DATA_W-1:0];
    end else begin
      product_nxt = rnd_s3_r[umc_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    product_r <= product_nxt;
    sat_r     <= over;
  end

  assign product = product_r;
  assign sat     = sat_r;

endmodule

### rtl/core/umc_front.sv
// ----------------------------------------------------------------------------
// umc_front
// Input register stage: neighbor sums, Laplacian stencils, pressure
// difference, then upwind selection of the flux velocities.
// ----------------------------------------------------------------------------
module umc_front (
  input  logic            clk,
  input  logic            load,
  input  logic            in_command,
  input  umc_pkg::data_t  in_vel_here,
  input  umc_pkg::data_t  in_vel_ahead,
  input  umc_pkg::data_t  in_vel_behind,
  input  umc_pkg::data_t  in_vel_side_plus,
  input  umc_pkg::data_t  in_vel_side_minus,
  input  umc_pkg::data_t  in_cross_plus_a,
  input  umc_pkg::data_t  in_cross_plus_b,
  input  umc_pkg::data_t  in_cross_minus_a,
  input  umc_pkg::data_t  in_cross_minus_b,
  input  umc_pkg::data_t  in_press_ahead,
  input  umc_pkg::data_t  in_press_here,
  output umc_pkg::front_t stg
);

  function automatic logic is_pos(input umc_pkg::sum_t v);
    return !v[umc_pkg::SUM_W-1] && (v != '0);
  endfunction

  logic           ydir_r;
  umc_pkg::data_t h_r, ah_r, bh_r, sp_r, sm_r;
  umc_pkg::sum_t  sa_nxt, sb_nxt, cp_nxt, cm_nxt, pdiff_nxt;
  umc_pkg::sum_t  sa_r, sb_r, cp_r, cm_r, pdiff_r;
  umc_pkg::op_t   h2, lap_al_nxt, lap_ac_nxt, lap_al_r, lap_ac_r;

  always_comb begin
    sa_nxt     = umc_pkg::sx_sum(in_vel_here) + umc_pkg::sx_sum(in_vel_ahead);
    sb_nxt     = umc_pkg::sx_sum(in_vel_here) + umc_pkg::sx_sum(in_vel_behind);
    cp_nxt     = umc_pkg::sx_sum(in_cross_plus_a) + umc_pkg::sx_sum(in_cross_plus_b);
    cm_nxt     = umc_pkg::sx_sum(in_cross_minus_a) + umc_pkg::sx_sum(in_cross_minus_b);
    pdiff_nxt  = umc_pkg::sx_sum(in_press_ahead) - umc_pkg::sx_sum(in_press_here);
    h2         = umc_pkg::sx_op(umc_pkg::sx_sum(in_vel_here)) <<< 1;
    lap_al_nxt = umc_pkg::sx_op(umc_pkg::sx_sum(in_vel_ahead))
                 + umc_pkg::sx_op(umc_pkg::sx_sum(in_vel_behind)) - h2;
    lap_ac_nxt = umc_pkg::sx_op(umc_pkg::sx_sum(in_vel_side_plus))
                 + umc_pkg::sx_op(umc_pkg::sx_sum(in_vel_side_minus)) - h2;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ydir_r   <= in_command;
      h_r      <= in_vel_here;
      ah_r     <= in_vel_ahead;
      bh_r     <= in_vel_behind;
      sp_r     <= in_vel_side_plus;
      sm_r     <= in_vel_side_minus;
      sa_r     <= sa_nxt;
      sb_r     <= sb_nxt;
      cp_r     <= cp_nxt;
      cm_r     <= cm_nxt;
      pdiff_r  <= pdiff_nxt;
      lap_al_r <= lap_al_nxt;
      lap_ac_r <= lap_ac_nxt;
    end
  end

  always_comb begin
    stg.ydir   = ydir_r;
    stg.h      = h_r;
    stg.upa    = is_pos(sa_r) ? h_r : ah_r;
    stg.upb    = is_pos(sb_r) ? bh_r : h_r;
    stg.upp    = is_pos(cp_r) ? h_r : sp_r;
    stg.upm    = is_pos(cm_r) ? sm_r : h_r;
    stg.sa     = sa_r;
    stg.sb     = sb_r;
    stg.cp     = cp_r;
    stg.cm     = cm_r;
    stg.lap_al = lap_al_r;
    stg.lap_ac = lap_ac_r;
    stg.pdiff  = pdiff_r;
  end

endmodule

### rtl/core/upwind_momentum_cell_update_top.sv
// ----------------------------------------------------------------------------
// upwind_momentum_cell_update_top
// out_valid is the end of a valid shift register that runs beside the data
// path. Throughput: one cell per clock while busy is low; receiver never stalls.
// Depth is set by three chained 5-stage multipliers plus four adder stages.
// Synchronous active-low reset clears the valid pipe and loads register
// defaults; busy is the inverted reset, registered, so it falls in the cycle after rst_n rises.
// ----------------------------------------------------------------------------
module upwind_momentum_cell_update_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_command,
  input  umc_pkg::data_t                   in_vel_here,
  input  umc_pkg::data_t                   in_vel_ahead,
  input  umc_pkg::data_t                   in_vel_behind,
  input  umc_pkg::data_t                   in_vel_side_plus,
  input  umc_pkg::data_t                   in_vel_side_minus,
  input  umc_pkg::data_t                   in_cross_plus_a,
  input  umc_pkg::data_t                   in_cross_plus_b,
  input  umc_pkg::data_t                   in_cross_minus_a,
  input  umc_pkg::data_t                   in_cross_minus_b,
  input  umc_pkg::data_t                   in_press_ahead,
  input  umc_pkg::data_t                   in_press_here,
  output logic                             out_valid,
  output umc_pkg::data_t                   out_new_velocity,
  output logic                             out_overflow,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [umc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  umc_pkg::reg_t                    cfg_data
);

  logic             busy_r, accept;
  logic [umc_pkg::LAT-1:0] vld_r;

  umc_pkg::reg_t    time_step_r, inv_dx_r, inv_dy_r;
  umc_pkg::reg_t    inv_dx_sq_r, inv_dy_sq_r, inv_reynolds_r;

  umc_pkg::front_t  fr;
  umc_pkg::reg_t    inv_al_t0, inv_al2_t0, inv_ac2_t0, inv_al_d1, inv_ac_d1;

  umc_pkg::data_t   fa, fb, fp, fm, lap_a, lap_c, grd;
  logic [6:0]       sat_l1;
  umc_pkg::data_t   adv_a, adv_c, dif, inc;
  logic             sat_adv_a, sat_adv_c, sat_dif, sat_inc;

  logic [umc_pkg::MUL_LAT:0]   ydir_p_r;
  umc_pkg::data_t   h_p_r   [umc_pkg::H_DLY];
  umc_pkg::data_t   grd_p_r [umc_pkg::MUL_LAT+1];
  logic [umc_pkg::MUL_LAT-1:0] sat1_p_r, sat2_p_r;

  umc_pkg::sum_t    flux_al_r, flux_ac_r, lap_r;
  logic             sat_d1_r, sat_d2_r;
  umc_pkg::op_t     inc_op_nxt, inc_op_r;

  umc_pkg::sum_t    fin_sum;
  logic             fin_clamp;
  umc_pkg::data_t   new_vel_nxt, out_new_velocity_r;
  logic             out_overflow_r;

  // ---- handshake ----
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy      = busy_r;
  assign accept    = start && !busy_r;
  assign cfg_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[umc_pkg::LAT-2:0], accept};
    end
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r    <= umc_pkg::TIME_STEP_RST;
      inv_dx_r       <= umc_pkg::INV_D_RST;
      inv_dy_r       <= umc_pkg::INV_D_RST;
      inv_dx_sq_r    <= umc_pkg::INV_D_SQ_RST;
      inv_dy_sq_r    <= umc_pkg::INV_D_SQ_RST;
      inv_reynolds_r <= umc_pkg::INV_REYNOLDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        umc_pkg::REG_TIME_STEP:      time_step_r    <= cfg_data;
        umc_pkg::REG_INV_DX:         inv_dx_r       <= cfg_data;
        umc_pkg::REG_INV_DY:         inv_dy_r       <= cfg_data;
        umc_pkg::REG_INV_DX_SQUARED: inv_dx_sq_r    <= cfg_data;
        umc_pkg::REG_INV_DY_SQUARED: inv_dy_sq_r    <= cfg_data;
        umc_pkg::REG_INV_REYNOLDS:   inv_reynolds_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- input stage ----
  umc_front u_front (
    .clk               (clk),
    .load              (accept),
    .in_command        (in_command),
    .in_vel_here       (in_vel_here),
    .in_vel_ahead      (in_vel_ahead),
    .in_vel_behind     (in_vel_behind),
    .in_vel_side_plus  (in_vel_side_plus),
    .in_vel_side_minus (in_vel_side_minus),
    .in_cross_plus_a   (in_cross_plus_a),
    .in_cross_plus_b   (in_cross_plus_b),
    .in_cross_minus_a  (in_cross_minus_a),
    .in_cross_minus_b  (in_cross_minus_b),
    .in_press_ahead    (in_press_ahead),
    .in_press_here     (in_press_here),
    .stg               (fr)
  );

  // x: along = x, across = y; y: swapped
  always_comb begin
    inv_al_t0  = fr.ydir ? inv_dy_r : inv_dx_r;
    inv_al2_t0 = fr.ydir ? inv_dy_sq_r : inv_dx_sq_r;
    inv_ac2_t0 = fr.ydir ? inv_dx_sq_r : inv_dy_sq_r;
  end

  // ---- level 1: fluxes, Laplacian terms, pressure gradient ----
  umc_fmul u_mul_fa (
    .clk(clk), .op_a(umc_pkg::sx_op(umc_pkg::sx_sum(fr.upa))),
    .op_b(umc_pkg::sx_op(fr.sa)), .half(1'b0), .product(fa), .sat(sat_l1[0])
  );
  umc_fmul u_mul_fb (
    .clk(clk), .op_a(umc_pkg::sx_op(umc_pkg::sx_sum(fr.upb))),
    .op_b(umc_pkg::sx_op(fr.sb)), .half(1'b0), .product(fb), .sat(sat_l1[1])
  );
  umc_fmul u_mul_fp (
    .clk(clk), .op_a(umc_pkg::sx_op(umc_pkg::sx_sum(fr.upp))),
    .op_b(umc_pkg::sx_op(fr.cp)), .half(1'b0), .product(fp), .sat(sat_l1[2])
  );
  umc_fmul u_mul_fm (
    .clk(clk), .op_a(umc_pkg::sx_op(umc_pkg::sx_sum(fr.upm))),
    .op_b(umc_pkg::sx_op(fr.cm)), .half(1'b0), .product(fm), .sat(sat_l1[3])
  );
  umc_fmul u_mul_lap_a (
    .clk(clk), .op_a(fr.lap_al), .op_b(umc_pkg::zx_op(inv_al2_t0)),
    .half(1'b0), .product(lap_a), .sat(sat_l1[4])
  );
  umc_fmul u_mul_lap_c (
    .clk(clk), .op_a(fr.lap_ac), .op_b(umc_pkg::zx_op(inv_ac2_t0)),
    .half(1'b0), .product(lap_c), .sat(sat_l1[5])
  );
  umc_fmul u_mul_grd (
    .clk(clk), .op_a(umc_pkg::sx_op(fr.pdiff)), .op_b(umc_pkg::zx_op(inv_al_t0)),
    .half(1'b0), .product(grd), .sat(sat_l1[6])
  );

  // ---- delay lines ----
  always_ff @(posedge clk) begin
    ydir_p_r <= {ydir_p_r[umc_pkg::MUL_LAT-1:0], fr.ydir};
    sat1_p_r <= {sat1_p_r[umc_pkg::MUL_LAT-2:0], sat_d1_r};
    sat2_p_r <= {sat2_p_r[umc_pkg::MUL_LAT-2:0], sat_d2_r};
    h_p_r[0]   <= fr.h;
    grd_p_r[0] <= grd;
    for (int k = 1; k < umc_pkg::H_DLY; k++) begin
      h_p_r[k] <= h_p_r[k-1];
    end
    for (int k = 1; k <= umc_pkg::MUL_LAT; k++) begin
      grd_p_r[k] <= grd_p_r[k-1];
    end
  end

  // ---- D1: flux and Laplacian sums ----
  always_ff @(posedge clk) begin
    flux_al_r <= umc_pkg::sx_sum(fa) - umc_pkg::sx_sum(fb);
    flux_ac_r <= umc_pkg::sx_sum(fp) - umc_pkg::sx_sum(fm);
    lap_r     <= umc_pkg::sx_sum(lap_a) + umc_pkg::sx_sum(lap_c);
    sat_d1_r  <= |sat_l1;
  end

  always_comb begin
    inv_al_d1 = ydir_p_r[umc_pkg::MUL_LAT] ? inv_dy_r : inv_dx_r;
    inv_ac_d1 = ydir_p_r[umc_pkg::MUL_LAT] ? inv_dx_r : inv_dy_r;
  end

  // ---- level 2: advection (with 1/2) and diffusion ----
  umc_fmul u_mul_adv_a (
    .clk(clk), .op_a(umc_pkg::sx_op(flux_al_r)), .op_b(umc_pkg::zx_op(inv_al_d1)),
    .half(1'b1), .product(adv_a), .sat(sat_adv_a)
  );
  umc_fmul u_mul_adv_c (
    .clk(clk), .op_a(umc_pkg::sx_op(flux_ac_r)), .op_b(umc_pkg::zx_op(inv_ac_d1)),
    .half(1'b1), .product(adv_c), .sat(sat_adv_c)
  );
  umc_fmul u_mul_dif (
    .clk(clk), .op_a(umc_pkg::sx_op(lap_r)), .op_b(umc_pkg::zx_op(inv_reynolds_r)),
    .half(1'b0), .product(dif), .sat(sat_dif)
  );

  // ---- D2: dif - adv - grd ----
  always_comb begin
    inc_op_nxt = umc_pkg::sx_op(umc_pkg::sx_sum(dif))
                 - umc_pkg::sx_op(umc_pkg::sx_sum(adv_a))
                 - umc_pkg::sx_op(umc_pkg::sx_sum(adv_c))
                 - umc_pkg::sx_op(umc_pkg::sx_sum(grd_p_r[umc_pkg::MUL_LAT]));
  end

  always_ff @(posedge clk) begin
    inc_op_r <= inc_op_nxt;
    sat_d2_r <= sat1_p_r[umc_pkg::MUL_LAT-1] | sat_adv_a | sat_adv_c | sat_dif;
  end

  // ---- level 3: time step ----
  umc_fmul u_mul_inc (
    .clk(clk), .op_a(inc_op_r), .op_b(umc_pkg::zx_op(time_step_r)),
    .half(1'b0), .product(inc), .sat(sat_inc)
  );

  // ---- final add and clamp ----
  always_comb begin
    fin_sum   = umc_pkg::sx_sum(h_p_r[umc_pkg::H_DLY-1]) + umc_pkg::sx_sum(inc);
    fin_clamp = fin_sum[umc_pkg::SUM_W-1] != fin_sum[umc_pkg::SUM_W-2];
    if (fin_clamp) begin
      new_vel_nxt = fin_sum[umc_pkg::SUM_W-1] ? umc_pkg::DATA_MIN : umc_pkg::DATA_MAX;
    end else begin
      new_vel_nxt = fin_sum[umc_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_new_velocity_r <= new_vel_nxt;
    out_overflow_r     <= sat2_p_r[umc_pkg::MUL_LAT-1] | sat_inc | fin_clamp;
  end

  assign out_valid        = vld_r[umc_pkg::LAT-1];
  assign out_new_velocity = out_new_velocity_r;
  assign out_overflow     = out_overflow_r;

`ifndef ASSERT_OFF
  ap_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, umc_pkg::LAT))
    else $error("result strobe without a transaction accepted LAT cycles earlier");

  ap_clamp_flags: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[umc_pkg::LAT-2] && fin_clamp |=> out_valid && out_overflow)
    else $error("final clamp did not raise overflow");

  ap_zero_inc: assert property (@(posedge clk) disable iff (!rst_n)
    inc_op_r == '0 |-> ##(umc_pkg::MUL_LAT) (inc == '0 && !sat_inc))
    else $error("time step multiply misaligned or wrong for zero operand");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Upwind momentum cell update testbench
// Feeds x and y velocity faces through the command port and checks every
// updated velocity and overflow flag against an in-bench fixed-point
// predictor. The run covers the field extremes, upwind ties, rounding ties
// and saturation, and then random faces under several register settings and
// sender idle rates.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic CMD_X = 1'b0;
  localparam logic CMD_Y = 1'b1;
  localparam int NUM_REGS = int'(umc_pkg::REG_INV_REYNOLDS) + 1;
  localparam int REPORT_LIMIT = 10;
  localparam int FACES_PER_PHASE = 140;
  localparam int SET_MAX = 0;
  localparam int SET_ZERO = 1;
  localparam int SET_FLOW = 2;
  localparam int SET_WILD = 3;
  localparam umc_pkg::data_t DATA_MAX = umc_pkg::DATA_MAX;
  localparam umc_pkg::data_t DATA_MIN = umc_pkg::DATA_MIN;
  localparam umc_pkg::data_t ULP = umc_pkg::data_t'(1);
  localparam longint SAT_HI = longint'(DATA_MAX);
  localparam longint SAT_LO = longint'(DATA_MIN);
  localparam logic [127:0] MAG_POS = 128'(SAT_HI);
  localparam logic [127:0] MAG_NEG = 128'(SAT_HI) + 128'd1;
  localparam umc_pkg::data_t UNIT = umc_pkg::data_t'(longint'(1) << umc_pkg::FRAC_BITS);

  typedef struct {
    logic           cmd;
    umc_pkg::data_t here;
    umc_pkg::data_t ahead;
    umc_pkg::data_t behind;
    umc_pkg::data_t side_plus;
    umc_pkg::data_t side_minus;
    umc_pkg::data_t cross_pa;
    umc_pkg::data_t cross_pb;
    umc_pkg::data_t cross_ma;
    umc_pkg::data_t cross_mb;
    umc_pkg::data_t press_ahead;
    umc_pkg::data_t press_here;
  } face_t;

  typedef struct {
    umc_pkg::data_t velocity;
    logic           overflow;
  } update_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  umc_pkg::data_t in_vel_here = '0;
  umc_pkg::data_t in_vel_ahead = '0;
  umc_pkg::data_t in_vel_behind = '0;
  umc_pkg::data_t in_vel_side_plus = '0;
  umc_pkg::data_t in_vel_side_minus = '0;
  umc_pkg::data_t in_cross_plus_a = '0;
  umc_pkg::data_t in_cross_plus_b = '0;
  umc_pkg::data_t in_cross_minus_a = '0;
  umc_pkg::data_t in_cross_minus_b = '0;
  umc_pkg::data_t in_press_ahead = '0;
  umc_pkg::data_t in_press_here = '0;
  logic out_valid;
  umc_pkg::data_t out_new_velocity;
  logic out_overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [umc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  umc_pkg::reg_t cfg_data = '0;

  face_t pending_faces[$];
  update_t expected_updates[$];
  update_t oldest_update;
  umc_pkg::reg_t active_regs[NUM_REGS];
  umc_pkg::reg_t next_regs[NUM_REGS];
  bit clip_seen;
  int send_gap_pct = 18;
  int fail_count = 0;

  upwind_momentum_cell_update_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_vel_here      (in_vel_here),
    .in_vel_ahead     (in_vel_ahead),
    .in_vel_behind    (in_vel_behind),
    .in_vel_side_plus (in_vel_side_plus),
    .in_vel_side_minus(in_vel_side_minus),
    .in_cross_plus_a  (in_cross_plus_a),
    .in_cross_plus_b  (in_cross_plus_b),
    .in_cross_minus_a (in_cross_minus_a),
    .in_cross_minus_b (in_cross_minus_b),
    .in_press_ahead   (in_press_ahead),
    .in_press_here    (in_press_here),
    .out_valid        (out_valid),
    .out_new_velocity (out_new_velocity),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // a*b / 2^sh, nearest with ties away from zero, clipped to 48 bits
  function automatic longint round_mul(input longint a, input longint b, input int sh);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] mag;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mag = ((ma * mb) + (128'd1 << (sh - 1))) >> sh;
    if (mag > (neg ? MAG_NEG : MAG_POS)) begin
      clip_seen = 1'b1;
      return neg ? SAT_LO : SAT_HI;
    end
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic update_t predict_update(input face_t f);
    longint h, ah, bh, sp, sm, cp, cm, sa, sb;
    longint inv_al, inv_ac, inv_al2, inv_ac2;
    longint upa, upb, upp, upm, fa, fb, fp, fm;
    longint adv, lap, dif, grd, inc, sum;
    update_t u;
    clip_seen = 1'b0;
    h = f.here;
    ah = f.ahead;
    bh = f.behind;
    sp = f.side_plus;
    sm = f.side_minus;
    cp = longint'(f.cross_pa) + longint'(f.cross_pb);
    cm = longint'(f.cross_ma) + longint'(f.cross_mb);
    if (f.cmd == CMD_Y) begin
      inv_al = active_regs[umc_pkg::REG_INV_DY];
      inv_ac = active_regs[umc_pkg::REG_INV_DX];
      inv_al2 = active_regs[umc_pkg::REG_INV_DY_SQUARED];
      inv_ac2 = active_regs[umc_pkg::REG_INV_DX_SQUARED];
    end else begin
      inv_al = active_regs[umc_pkg::REG_INV_DX];
      inv_ac = active_regs[umc_pkg::REG_INV_DY];
      inv_al2 = active_regs[umc_pkg::REG_INV_DX_SQUARED];
      inv_ac2 = active_regs[umc_pkg::REG_INV_DY_SQUARED];
    end
    sa = h + ah;
    sb = h + bh;
    upa = (sa > 0) ? h : ah;
    upb = (sb > 0) ? bh : h;
    upp = (cp > 0) ? h : sp;
    upm = (cm > 0) ? sm : h;
    fa = round_mul(upa, sa, umc_pkg::FRAC_BITS);
    fb = round_mul(upb, sb, umc_pkg::FRAC_BITS);
    fp = round_mul(upp, cp, umc_pkg::FRAC_BITS);
    fm = round_mul(upm, cm, umc_pkg::FRAC_BITS);
    adv = round_mul(fa - fb, inv_al, umc_pkg::FRAC_BITS + 1)
        + round_mul(fp - fm, inv_ac, umc_pkg::FRAC_BITS + 1);
    lap = round_mul(ah - 2 * h + bh, inv_al2, umc_pkg::FRAC_BITS)
        + round_mul(sp - 2 * h + sm, inv_ac2, umc_pkg::FRAC_BITS);
    dif = round_mul(lap, longint'(active_regs[umc_pkg::REG_INV_REYNOLDS]),
                    umc_pkg::FRAC_BITS);
    grd = round_mul(longint'(f.press_ahead) - longint'(f.press_here), inv_al,
                    umc_pkg::FRAC_BITS);
    inc = round_mul(dif - adv - grd, longint'(active_regs[umc_pkg::REG_TIME_STEP]),
                    umc_pkg::FRAC_BITS);
    sum = h + inc;
    if (sum > SAT_HI) begin
      sum = SAT_HI;
      clip_seen = 1'b1;
    end else if (sum < SAT_LO) begin
      sum = SAT_LO;
      clip_seen = 1'b1;
    end
    u.velocity = umc_pkg::data_t'(sum);
    u.overflow = clip_seen;
    return u;
  endfunction

  function automatic longint rand_bits(input int k);
    longint v;
    v = {$urandom, $urandom};
    if (k < 64) v = v & ((longint'(1) << k) - 1);
    return v;
  endfunction

  function automatic longint rand_signed(input int kmin, input int kmax);
    longint v;
    v = rand_bits($urandom_range(kmax, kmin));
    return ($urandom_range(1) == 1) ? -v : v;
  endfunction

  function automatic umc_pkg::data_t rand_field();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(4))
        0: return '0;
        1: return DATA_MAX;
        2: return DATA_MIN;
        3: return ULP;
        default: return -ULP;
      endcase
    end
    if (pick < 45) return umc_pkg::data_t'(rand_bits(umc_pkg::DATA_W));
    return umc_pkg::data_t'(rand_signed(1, umc_pkg::DATA_W - 1));
  endfunction

  // mostly smooth flow fields, the rest arbitrary bit patterns
  function automatic face_t rand_face();
    face_t f;
    longint base, cbase, pbase;
    f.cmd = logic'($urandom_range(1));
    if ($urandom_range(9) < 7) begin
      base = rand_signed(24, 36);
      cbase = rand_signed(24, 36);
      pbase = rand_signed(16, 40);
      f.here = umc_pkg::data_t'(base);
      f.ahead = umc_pkg::data_t'(base + rand_signed(8, 32));
      f.behind = umc_pkg::data_t'(base + rand_signed(8, 32));
      f.side_plus = umc_pkg::data_t'(base + rand_signed(8, 32));
      f.side_minus = umc_pkg::data_t'(base + rand_signed(8, 32));
      f.cross_pa = umc_pkg::data_t'(cbase + rand_signed(8, 32));
      f.cross_pb = umc_pkg::data_t'(cbase + rand_signed(8, 32));
      f.cross_ma = umc_pkg::data_t'(cbase + rand_signed(8, 32));
      f.cross_mb = umc_pkg::data_t'(cbase + rand_signed(8, 32));
      f.press_ahead = umc_pkg::data_t'(pbase + rand_signed(8, 34));
      f.press_here = umc_pkg::data_t'(pbase);
    end else begin
      f.here = rand_field();
      f.ahead = rand_field();
      f.behind = rand_field();
      f.side_plus = rand_field();
      f.side_minus = rand_field();
      f.cross_pa = rand_field();
      f.cross_pb = rand_field();
      f.cross_ma = rand_field();
      f.cross_mb = rand_field();
      f.press_ahead = rand_field();
      f.press_here = rand_field();
    end
    return f;
  endfunction

  function automatic face_t mk_face(input logic cmd, input umc_pkg::data_t h,
                                    input umc_pkg::data_t ah, input umc_pkg::data_t bh,
                                    input umc_pkg::data_t sp, input umc_pkg::data_t sm,
                                    input umc_pkg::data_t cpa, input umc_pkg::data_t cpb,
                                    input umc_pkg::data_t cma, input umc_pkg::data_t cmb,
                                    input umc_pkg::data_t pa, input umc_pkg::data_t ph);
    face_t f;
    f.cmd = cmd;
    f.here = h;
    f.ahead = ah;
    f.behind = bh;
    f.side_plus = sp;
    f.side_minus = sm;
    f.cross_pa = cpa;
    f.cross_pb = cpb;
    f.cross_ma = cma;
    f.cross_mb = cmb;
    f.press_ahead = pa;
    f.press_here = ph;
    return f;
  endfunction

  // writes next_regs plus the unused index slots, then drops valid
  task automatic program_regs();
    int i;
    @(posedge clk);
    for (i = 0; i < (1 << umc_pkg::CFG_IDX_W); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= umc_pkg::CFG_IDX_W'(i);
      cfg_data <= (i < NUM_REGS) ? next_regs[i]
                                 : umc_pkg::reg_t'(rand_bits(umc_pkg::REG_W));
      do @(posedge clk); while (!cfg_ready);
      if (i < NUM_REGS) active_regs[i] = next_regs[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_faces.size() != 0 || expected_updates.size() != 0) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_updates.push_back(predict_update(pending_faces[0]));
        void'(pending_faces.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_faces.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_command <= pending_faces[0].cmd;
          in_vel_here <= pending_faces[0].here;
          in_vel_ahead <= pending_faces[0].ahead;
          in_vel_behind <= pending_faces[0].behind;
          in_vel_side_plus <= pending_faces[0].side_plus;
          in_vel_side_minus <= pending_faces[0].side_minus;
          in_cross_plus_a <= pending_faces[0].cross_pa;
          in_cross_plus_b <= pending_faces[0].cross_pb;
          in_cross_minus_a <= pending_faces[0].cross_ma;
          in_cross_minus_b <= pending_faces[0].cross_mb;
          in_press_ahead <= pending_faces[0].press_ahead;
          in_press_here <= pending_faces[0].press_here;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_updates.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected transaction: velocity %0d overflow %0b",
                   out_new_velocity, out_overflow);
      end else begin
        oldest_update = expected_updates.pop_front();
        if (out_new_velocity !== oldest_update.velocity ||
            out_overflow !== oldest_update.overflow) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: velocity exp %0d got %0d, overflow exp %0b got %0b",
                     oldest_update.velocity, out_new_velocity,
                     oldest_update.overflow, out_overflow);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int stage, kind, n;
    active_regs[umc_pkg::REG_TIME_STEP] = umc_pkg::TIME_STEP_RST;
    active_regs[umc_pkg::REG_INV_DX] = umc_pkg::INV_D_RST;
    active_regs[umc_pkg::REG_INV_DY] = umc_pkg::INV_D_RST;
    active_regs[umc_pkg::REG_INV_DX_SQUARED] = umc_pkg::INV_D_SQ_RST;
    active_regs[umc_pkg::REG_INV_DY_SQUARED] = umc_pkg::INV_D_SQ_RST;
    active_regs[umc_pkg::REG_INV_REYNOLDS] = umc_pkg::INV_REYNOLDS_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed faces under reset register values
    pending_faces.push_back(mk_face(CMD_X, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    pending_faces.push_back(mk_face(CMD_Y, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    pending_faces.push_back(mk_face(CMD_X, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                                    DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
    pending_faces.push_back(mk_face(CMD_Y, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                                    DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
    pending_faces.push_back(mk_face(CMD_X, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN,
                                    DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN));
    pending_faces.push_back(mk_face(CMD_Y, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX,
                                    DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX));
    // upwind sums exactly zero
    pending_faces.push_back(mk_face(CMD_X, UNIT, -UNIT, -UNIT, 2 * UNIT, 3 * UNIT,
                                    UNIT, -UNIT, -UNIT, UNIT, UNIT, '0));
    pending_faces.push_back(mk_face(CMD_Y, UNIT, -UNIT, -UNIT, 2 * UNIT, 3 * UNIT,
                                    UNIT, -UNIT, -UNIT, UNIT, '0, UNIT));
    pending_faces.push_back(mk_face(CMD_X, UNIT, UNIT >>> 1, UNIT >>> 2, UNIT >>> 3, -UNIT,
                                    UNIT, '0, UNIT, '0, UNIT >>> 4, '0));
    pending_faces.push_back(mk_face(CMD_Y, -UNIT, -(UNIT >>> 1), -(UNIT >>> 2), UNIT, UNIT >>> 3,
                                    -UNIT, '0, -UNIT, '0, '0, UNIT >>> 4));
    // rounding ties of the ahead flux
    pending_faces.push_back(mk_face(CMD_X, umc_pkg::data_t'(65536),
                                    umc_pkg::data_t'(-32768), '0, '0, '0,
                                    '0, '0, '0, '0, '0, '0));
    pending_faces.push_back(mk_face(CMD_X, umc_pkg::data_t'(-65536),
                                    umc_pkg::data_t'(98304), '0, '0, '0,
                                    '0, '0, '0, '0, '0, '0));
    // final sum and product clipping
    pending_faces.push_back(mk_face(CMD_X, DATA_MAX, '0, '0, '0, '0,
                                    '0, '0, '0, '0, DATA_MIN, '0));
    pending_faces.push_back(mk_face(CMD_Y, DATA_MIN, '0, '0, '0, '0,
                                    '0, '0, '0, '0, DATA_MAX, '0));
    pending_faces.push_back(mk_face(CMD_X, DATA_MIN, DATA_MIN, '0, '0, '0,
                                    '0, '0, '0, '0, '0, '0));
    pending_faces.push_back(mk_face(CMD_Y, '0, '0, '0, '0, '0, '0, '0, '0, '0, UNIT, -UNIT));
    pending_faces.push_back(mk_face(CMD_X, '0, UNIT, UNIT, -UNIT, UNIT >>> 1,
                                    '0, '0, '0, '0, '0, '0));
    pending_faces.push_back(mk_face(CMD_Y, UNIT >>> 3, '0, '0, -(UNIT >>> 3), UNIT >>> 4,
                                    DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN, '0, '0));
    pending_faces.push_back(mk_face(CMD_X, ULP, ULP, ULP, ULP, ULP, ULP, ULP, ULP,
                                    ULP, ULP, ULP));
    pending_faces.push_back(mk_face(CMD_Y, -ULP, -ULP, -ULP, -ULP, -ULP, -ULP, -ULP, -ULP,
                                    -ULP, -ULP, -ULP));

    for (stage = 0; stage < 3; stage++) begin
      for (kind = SET_MAX; kind <= SET_WILD; kind++) begin
        wait_drained();
        send_gap_pct = (stage == 0) ? 18 : (stage == 1) ? 82 : 0;
        case (kind)
          SET_MAX: foreach (next_regs[i]) next_regs[i] = '1;
          SET_ZERO: foreach (next_regs[i]) next_regs[i] = '0;
          SET_FLOW: begin
            next_regs[umc_pkg::REG_TIME_STEP] =
              umc_pkg::reg_t'(rand_bits($urandom_range(34, 20)));
            next_regs[umc_pkg::REG_INV_DX] =
              umc_pkg::reg_t'(rand_bits($urandom_range(40, 33)));
            next_regs[umc_pkg::REG_INV_DY] =
              umc_pkg::reg_t'(rand_bits($urandom_range(40, 33)));
            next_regs[umc_pkg::REG_INV_DX_SQUARED] =
              umc_pkg::reg_t'(rand_bits($urandom_range(46, 36)));
            next_regs[umc_pkg::REG_INV_DY_SQUARED] =
              umc_pkg::reg_t'(rand_bits($urandom_range(46, 36)));
            next_regs[umc_pkg::REG_INV_REYNOLDS] =
              umc_pkg::reg_t'(rand_bits($urandom_range(34, 20)));
          end
          default: begin
            foreach (next_regs[i]) begin
              next_regs[i] = umc_pkg::reg_t'(rand_bits($urandom_range(umc_pkg::REG_W, 1)));
            end
          end
        endcase
        program_regs();
        for (n = 0; n < FACES_PER_PHASE; n++) pending_faces.push_back(rand_face());
      end
    end

    wait_drained();
    repeat (umc_pkg::LAT + 10) @(posedge clk);
    if (fail_count == 0 && expected_updates.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
